// ----- src/tcrs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcrs_pkg
// Shared types and constants for the totalistic cellular automaton rhythm
// search core: register map, rule actions, field widths and control structs.
// ----------------------------------------------------------------------------
package tcrs_pkg;

  // Fixed field widths
  localparam int unsigned PAT_W     = 32;
  localparam int unsigned RULE_W    = 8;
  localparam int unsigned DIST_W    = 10;
  localparam int unsigned GEN_W     = 16;
  localparam int unsigned ONSET_W   = 6;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [GEN_W-1:0] MAX_GEN_RESET = GEN_W'(1000);

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_PATTERN = 4'd0,
    CFG_RULE_CODES   = 4'd1,
    CFG_DIST_LIMIT   = 4'd2,
    CFG_MAX_GEN      = 4'd3
  } cfg_reg_e;

  // Per-count cell action
  typedef enum logic [1:0] {
    ACT_KEEP  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_SET   = 2'd2,
    ACT_FLIP  = 2'd3
  } cell_act_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2
  } seq_state_e;

  // Configuration register set
  typedef struct packed {
    logic [PAT_W-1:0]  init_pattern;
    logic [RULE_W-1:0] rule_codes;
    logic [DIST_W-1:0] distance_limit;
    logic [GEN_W-1:0]  max_generations;
  } cfg_t;

  // Per-cycle control from the sequencer to the serial datapath
  typedef struct packed {
    logic load;     // request accepted, prime the pass
    logic active;   // one cell processed this cycle
    logic first;    // leftmost edge cell
    logic last;     // rightmost edge cell
    logic note;     // a note cell (not an edge)
    logic restart;  // reload rather than evolve
  } step_ctrl_t;

  // Comparison results at the end of a pass
  typedef struct packed {
    logic [ONSET_W-1:0] onset_count;
    logic               same_count;
    logic [DIST_W-1:0]  move_dist;
  } metric_t;

endpackage

// ----- src/tcrs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tcrs_cfg_regs
// Configuration register file, written through an indexed write channel.
// ----------------------------------------------------------------------------
module tcrs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tcrs_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output tcrs_pkg::cfg_t                cfg_o
);
  import tcrs_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INIT_PATTERN: cfg_d.init_pattern    = cfg_data_i[PAT_W-1:0];
        CFG_RULE_CODES:   cfg_d.rule_codes      = cfg_data_i[RULE_W-1:0];
        CFG_DIST_LIMIT:   cfg_d.distance_limit  = cfg_data_i[DIST_W-1:0];
        CFG_MAX_GEN:      cfg_d.max_generations = cfg_data_i[GEN_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_pattern    <= '0;
      cfg_q.rule_codes      <= '0;
      cfg_q.distance_limit  <= '0;
      cfg_q.max_generations <= MAX_GEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/tcrs_cell_row.sv -----
// ----------------------------------------------------------------------------
// tcrs_cell_row
// Circulating cell row. While ctrl_i.active is high, one cell is updated
// per cycle: the old cell leaves at bit 0 and its new value enters at the
// top; a full pass over the ROW cells leaves the next generation in place.
// ----------------------------------------------------------------------------
module tcrs_cell_row #(
  parameter int unsigned NOTES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcrs_pkg::step_ctrl_t          ctrl_i,
  input  logic [tcrs_pkg::RULE_W-1:0]   rule_codes_i,
  input  logic                          init_bit_i,
  output logic                          new_bit_o,
  output logic [NOTES-1:0]              notes_o
);
  import tcrs_pkg::*;

  localparam int unsigned ROW = NOTES + 2;

  logic [ROW-1:0] row_q, row_d;
  logic           prev_q;        // old value of the cell just processed
  logic           cur_v, left_v, right_v;
  logic [1:0]     sum_v;
  cell_act_e      act_v;
  logic           new_v;

  // Totalistic update of the cell at bit 0
  always_comb begin
    cur_v   = row_q[0];
    left_v  = ctrl_i.first ? 1'b0 : prev_q;
    right_v = ctrl_i.last  ? 1'b0 : row_q[1];
    sum_v   = 2'({1'b0, cur_v}) + 2'({1'b0, left_v}) + 2'({1'b0, right_v});
    act_v   = cell_act_e'(rule_codes_i[{sum_v, 1'b0} +: 2]);
    unique case (act_v)
      ACT_KEEP:  new_v = cur_v;
      ACT_CLEAR: new_v = 1'b0;
      ACT_SET:   new_v = 1'b1;
      ACT_FLIP:  new_v = ~cur_v;
      default:   new_v = cur_v;
    endcase
    // Reload: notes from the initial pattern, edges cleared
    if (ctrl_i.restart) begin
      new_v = ctrl_i.note & init_bit_i;
    end
    row_d = row_q;
    if (ctrl_i.active) begin
      row_d = {new_v, row_q[ROW-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  // Left neighbor carry, scratch only
  always_ff @(posedge clk_i) begin
    if (ctrl_i.active) begin
      prev_q <= cur_v;
    end
  end

  assign new_bit_o = new_v;
  assign notes_o   = row_q[NOTES:1];

endmodule

// ----- src/tcrs_metric.sv -----
// ----------------------------------------------------------------------------
// tcrs_metric
// Bit-serial comparison of the new note cells with the initial pattern:
// onset counts and swap distance. The swap distance is accumulated as the
// sum over positions of |prefix onsets(initial) - prefix onsets(row)|, which
// equals the matched-onset distance when the counts agree.
// ----------------------------------------------------------------------------
module tcrs_metric #(
  parameter int unsigned NOTES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcrs_pkg::step_ctrl_t        ctrl_i,
  input  logic [tcrs_pkg::PAT_W-1:0]  init_pattern_i,
  input  logic                        new_bit_i,
  output logic                        init_bit_o,
  output tcrs_pkg::metric_t           metric_o
);
  import tcrs_pkg::*;

  localparam int unsigned CW = $clog2(NOTES + 1);

  logic [PAT_W-1:0]     init_sr_q, init_sr_d;
  logic [CW-1:0]        cnt_a_q, cnt_a_d;
  logic [CW-1:0]        cnt_b_q, cnt_b_d;
  logic signed [CW:0]   diff_q, diff_d;
  logic signed [CW:0]   neg_v;
  logic [CW-1:0]        abs_v;
  logic [DIST_W-1:0]    dist_q, dist_d;
  logic [DIST_W:0]      sum_v;
  logic                 a_v, b_v;

  // One note position per cycle, on cycles with an active note cell
  always_comb begin
    a_v       = init_sr_q[0];
    b_v       = new_bit_i;
    init_sr_d = init_sr_q;
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    diff_d    = diff_q;
    dist_d    = dist_q;
    neg_v     = '0;
    abs_v     = '0;
    sum_v     = '0;
    if (ctrl_i.load) begin
      init_sr_d = init_pattern_i;
      cnt_a_d   = '0;
      cnt_b_d   = '0;
      diff_d    = '0;
      dist_d    = '0;
    end else if (ctrl_i.active && ctrl_i.note) begin
      init_sr_d = {1'b0, init_sr_q[PAT_W-1:1]};
      cnt_a_d   = cnt_a_q + CW'(a_v);
      cnt_b_d   = cnt_b_q + CW'(b_v);
      diff_d    = diff_q + $signed({{CW{1'b0}}, a_v}) - $signed({{CW{1'b0}}, b_v});
      neg_v     = -diff_d;
      abs_v     = diff_d[CW] ? neg_v[CW-1:0] : diff_d[CW-1:0];
      // Saturating distance accumulate
      sum_v     = {1'b0, dist_q} + (DIST_W+1)'(abs_v);
      dist_d    = sum_v[DIST_W] ? '1 : sum_v[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      diff_q  <= '0;
      dist_q  <= '0;
    end else begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      diff_q  <= diff_d;
      dist_q  <= dist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    init_sr_q <= init_sr_d;
  end

  // Results, final once the pass is over
  always_comb begin
    metric_o.onset_count = ONSET_W'(cnt_b_q);
    metric_o.same_count  = (cnt_a_q == cnt_b_q);
    metric_o.move_dist   = (cnt_a_q == cnt_b_q) ? dist_q : '0;
  end

  assign init_bit_o = a_v;

endmodule

// ----- src/totalistic_ca_rhythm_search_core.sv -----
// ----------------------------------------------------------------------------
// totalistic_ca_rhythm_search_core
// Bit-serial one-dimensional totalistic cellular automaton rhythm search.
//
// Usage:
//   Configuration is written over cfg_valid_i/cfg_index_i/cfg_data_i while
//   the core is idle; cfg_ready_o is always high. Index 0 initial pattern,
//   1 rule codes, 2 distance limit, 3 generation limit; others are dropped.
//   Each input request (restart_i) either reloads the row from the initial
//   pattern or advances one generation, and yields one result request.
//   A request is taken when in_valid_i is high and in_stall_o low.
//   The cell row of NOTES+2 cells is processed one cell per cycle; after
//   this serial pass the result is loaded into the output register, and
//   only then does the core return to idle and take a new request.
//   The finished result sits in an output register; while out_stall_i is
//   high it holds and the core waits before overwriting it.
//   Reset clears the row, the generation count and the registers (the
//   generation limit resets to 1000); no clearing pass is needed.
// ----------------------------------------------------------------------------
module totalistic_ca_rhythm_search_core #(
  parameter int unsigned NOTES = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tcrs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tcrs_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  // Input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             restart_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [tcrs_pkg::PAT_W-1:0]       pattern_o,
  output logic [tcrs_pkg::ONSET_W-1:0]     onset_count_o,
  output logic                             same_count_o,
  output logic [tcrs_pkg::DIST_W-1:0]      move_dist_o,
  output logic                             found_o,
  output logic [tcrs_pkg::GEN_W-1:0]       generation_o,
  output logic                             exhausted_o
);
  import tcrs_pkg::*;

  localparam int unsigned ROW  = NOTES + 2;
  localparam int unsigned CNTW = $clog2(ROW);
  localparam int unsigned PW   = (NOTES > PAT_W) ? NOTES : PAT_W;
  localparam logic [CNTW-1:0] LAST_CELL = CNTW'(ROW - 1);

  cfg_t             cfg;
  step_ctrl_t       ctrl;
  metric_t          metric;
  seq_state_e       state_q, state_d;
  logic [CNTW-1:0]  cell_q, cell_d;
  logic             restart_q;
  logic [GEN_W-1:0] gen_q, gen_d;
  logic             accept_v, slot_free_v, result_load_v;
  logic             new_bit, init_bit;
  logic [NOTES-1:0] notes;
  logic [PW-1:0]    notes_ext;
  logic             found_v, exhausted_v;

  logic             out_valid_q;
  logic [PAT_W-1:0] pattern_q;
  logic [ONSET_W-1:0] onset_count_q;
  logic             same_count_q;
  logic [DIST_W-1:0] move_dist_q;
  logic             found_q;
  logic [GEN_W-1:0] generation_q;
  logic             exhausted_q;

  assign cfg_ready_o = 1'b1;

  tcrs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign slot_free_v = ~out_valid_q | ~out_stall_i;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_RUN;
      ST_RUN:  if (cell_q == LAST_CELL) state_d = ST_DONE;
      ST_DONE: if (slot_free_v) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o    = 1'b1;
    accept_v      = 1'b0;
    result_load_v = 1'b0;
    ctrl          = '0;
    ctrl.restart  = restart_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept_v   = in_valid_i;
        ctrl.load  = in_valid_i;
      end
      ST_RUN: begin
        ctrl.active = 1'b1;
        ctrl.first  = (cell_q == '0);
        ctrl.last   = (cell_q == LAST_CELL);
        ctrl.note   = (cell_q != '0) && (cell_q != LAST_CELL);
      end
      ST_DONE: result_load_v = slot_free_v;
      default: in_stall_o = 1'b1;
    endcase
  end

  // Cell counter and generation count
  always_comb begin
    cell_d = cell_q;
    if (accept_v) begin
      cell_d = '0;
    end else if (ctrl.active) begin
      cell_d = ctrl.last ? '0 : cell_q + 1'b1;
    end
    gen_d = gen_q;
    if (accept_v) begin
      if (restart_i) begin
        gen_d = '0;
      end else if (gen_q != '1) begin
        gen_d = gen_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cell_q    <= '0;
      restart_q <= 1'b0;
      gen_q     <= '0;
    end else begin
      state_q <= state_d;
      cell_q  <= cell_d;
      gen_q   <= gen_d;
      if (accept_v) begin
        restart_q <= restart_i;
      end
    end
  end

  tcrs_cell_row #(.NOTES(NOTES)) u_row (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .rule_codes_i (cfg.rule_codes),
    .init_bit_i   (init_bit),
    .new_bit_o    (new_bit),
    .notes_o      (notes)
  );

  tcrs_metric #(.NOTES(NOTES)) u_metric (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .init_pattern_i (cfg.init_pattern),
    .new_bit_i      (new_bit),
    .init_bit_o     (init_bit),
    .metric_o       (metric)
  );

  // Result flags
  assign notes_ext   = PW'(notes);
  assign found_v     = metric.same_count & ~restart_q &
                       (metric.move_dist <= cfg.distance_limit);
  assign exhausted_v = ~found_v & (gen_q >= cfg.max_generations);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result_load_v) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_load_v) begin
      pattern_q     <= notes_ext[PAT_W-1:0];
      onset_count_q <= metric.onset_count;
      same_count_q  <= metric.same_count;
      move_dist_q   <= metric.move_dist;
      found_q       <= found_v;
      generation_q  <= gen_q;
      exhausted_q   <= exhausted_v;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pattern_o     = pattern_q;
  assign onset_count_o = onset_count_q;
  assign same_count_o  = same_count_q;
  assign move_dist_o   = move_dist_q;
  assign found_o       = found_q;
  assign generation_o  = generation_q;
  assign exhausted_o   = exhausted_q;

endmodule

// ----- tb/sv/tb_totalistic_ca_rhythm_search_core.sv -----
// ----------------------------------------------------------------------------
// tb_totalistic_ca_rhythm_search_core
// Self-checking bench for the cellular automaton rhythm search core. A
// scoreboard class keeps its own copy of the cell row, generation count and
// registers, predicts one result per accepted step request and checks every
// result request field by field. Directed steps cover the register extremes
// and the limit cases. Random walks then run under changing rule sets, with
// random idling on both channels, one quiet stretch and one long output
// hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_totalistic_ca_rhythm_search_core;
  import tcrs_pkg::*;

  localparam int unsigned NOTES    = 32;
  localparam int unsigned ROW_W    = NOTES + 2;
  localparam int unsigned DIST_SAT = 1023;
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX = 4'd7;

  // One result request as seen on the output ports
  typedef struct packed {
    logic [PAT_W-1:0]   pattern;
    logic [ONSET_W-1:0] onset_count;
    logic               same_count;
    logic [DIST_W-1:0]  move_dist;
    logic               found;
    logic [GEN_W-1:0]   generation;
    logic               exhausted;
  } step_result_t;

  // Row predictor plus queue of results still owed by the core
  class rhythm_scoreboard;
    logic [PAT_W-1:0]  init_pattern;
    logic [RULE_W-1:0] rule_codes;
    logic [DIST_W-1:0] dist_limit;
    logic [GEN_W-1:0]  max_gen;
    logic [ROW_W-1:0]  row;
    logic [GEN_W-1:0]  gen_count;
    step_result_t      owed_q[$];
    int unsigned       errors;

    function new();
      init_pattern = '0;
      rule_codes   = '0;
      dist_limit   = '0;
      max_gen      = MAX_GEN_RESET;
      row          = '0;
      gen_count    = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_INIT_PATTERN: init_pattern = data[PAT_W-1:0];
        CFG_RULE_CODES:   rule_codes   = data[RULE_W-1:0];
        CFG_DIST_LIMIT:   dist_limit   = data[DIST_W-1:0];
        CFG_MAX_GEN:      max_gen      = data[GEN_W-1:0];
        default: ;
      endcase
    endfunction

    // One generation: each cell looks at itself and its existing neighbours
    function logic [ROW_W-1:0] next_gen(logic [ROW_W-1:0] cur);
      logic [ROW_W-1:0] nxt;
      logic             lft;
      logic             rgt;
      int unsigned      sum;
      cell_act_e        act;
      nxt = '0;
      for (int j = 0; j < ROW_W; j++) begin
        lft = (j > 0) ? cur[j-1] : 1'b0;
        rgt = (j < ROW_W - 1) ? cur[j+1] : 1'b0;
        sum = int'(cur[j]) + int'(lft) + int'(rgt);
        act = cell_act_e'(rule_codes[2*sum +: 2]);
        case (act)
          ACT_KEEP:  nxt[j] = cur[j];
          ACT_CLEAR: nxt[j] = 1'b0;
          ACT_SET:   nxt[j] = 1'b1;
          ACT_FLIP:  nxt[j] = ~cur[j];
          default:   nxt[j] = cur[j];
        endcase
      end
      return nxt;
    endfunction

    // k-th onset of one row matched with the k-th onset of the other
    function logic [DIST_W-1:0] swap_dist(logic [NOTES-1:0] a, logic [NOTES-1:0] b);
      int pa[NOTES];
      int pb[NOTES];
      int na;
      int nb;
      int unsigned total;
      na = 0;
      nb = 0;
      total = 0;
      for (int j = 0; j < NOTES; j++) begin
        if (a[j]) begin
          pa[na] = j;
          na++;
        end
        if (b[j]) begin
          pb[nb] = j;
          nb++;
        end
      end
      for (int k = 0; k < na && k < nb; k++) begin
        total += (pa[k] > pb[k]) ? pa[k] - pb[k] : pb[k] - pa[k];
      end
      if (total > DIST_SAT) total = DIST_SAT;
      return total[DIST_W-1:0];
    endfunction

    // Accepted step request: update state, queue the owed result
    function void note_request(logic restart);
      step_result_t     want;
      logic [NOTES-1:0] init_notes;
      logic [NOTES-1:0] notes;
      logic             advanced;
      int unsigned      cnt;
      int unsigned      cnt0;
      init_notes = init_pattern[NOTES-1:0];
      if (restart) begin
        row       = {1'b0, init_notes, 1'b0};
        gen_count = '0;
        advanced  = 1'b0;
      end else begin
        row = next_gen(row);
        if (gen_count != '1) gen_count++;
        advanced = 1'b1;
      end
      notes = row[NOTES:1];
      cnt   = $countones(notes);
      cnt0  = $countones(init_notes);
      want.pattern     = notes;
      want.onset_count = cnt[ONSET_W-1:0];
      want.same_count  = (cnt == cnt0);
      want.move_dist   = want.same_count ? swap_dist(init_notes, notes) : '0;
      want.found       = want.same_count && advanced && (want.move_dist <= dist_limit);
      want.generation  = gen_count;
      want.exhausted   = !want.found && (gen_count >= max_gen);
      owed_q.insert(owed_q.size(), want);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want, seen);
      end
    endfunction

    function void check_result(step_result_t got);
      step_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t ns: unrequested result, expected none, actual pattern 0x%0h",
                 $time, got.pattern);
        return;
      end
      want = owed_q.pop_front();
      compare_field("pattern", want.pattern, got.pattern);
      compare_field("onset_count", 32'(want.onset_count), 32'(got.onset_count));
      compare_field("same_count", 32'(want.same_count), 32'(got.same_count));
      compare_field("move_dist", 32'(want.move_dist), 32'(got.move_dist));
      compare_field("found", 32'(want.found), 32'(got.found));
      compare_field("generation", 32'(want.generation), 32'(got.generation));
      compare_field("exhausted", 32'(want.exhausted), 32'(got.exhausted));
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 restart_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [PAT_W-1:0]     pattern_o;
  logic [ONSET_W-1:0]   onset_count_o;
  logic                 same_count_o;
  logic [DIST_W-1:0]    move_dist_o;
  logic                 found_o;
  logic [GEN_W-1:0]     generation_o;
  logic                 exhausted_o;

  rhythm_scoreboard sb;
  int unsigned      items_sent;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      hold_req;

  totalistic_ca_rhythm_search_core #(
    .NOTES(NOTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pattern_o      (pattern_o),
    .onset_count_o  (onset_count_o),
    .same_count_o   (same_count_o),
    .move_dist_o    (move_dist_o),
    .found_o        (found_o),
    .generation_o   (generation_o),
    .exhausted_o    (exhausted_o)
  );

  always #5 clk_i = ~clk_i;

  // Watch both channels at the rising edge
  always @(posedge clk_i) begin : watch_ports
    step_result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(restart_i);
      if (out_valid_o && !out_stall_i) begin
        got.pattern     = pattern_o;
        got.onset_count = onset_count_o;
        got.same_count  = same_count_o;
        got.move_dist   = move_dist_o;
        got.found       = found_o;
        got.generation  = generation_o;
        got.exhausted   = exhausted_o;
        sb.check_result(got);
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != holds_served) begin
        hold_left    = 400;
        holds_served = hold_req;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #20000000;
    $display("FAIL totalistic_ca_rhythm_search_core");
    $finish;
  end

  // Register write; the scoreboard copy follows at the handshake
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One step request, with random idle cycles ahead of it
  task automatic send_step(input logic restart);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Stop offering and wait for every owed result
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Field value in the low bits, random bits above it
  function automatic logic [CFG_DAT_W-1:0] with_noise(logic [CFG_DAT_W-1:0] value, int width);
    logic [CFG_DAT_W-1:0] mask;
    mask = (width >= CFG_DAT_W) ? '1 : ((CFG_DAT_W'(1) << width) - 1);
    return ($urandom() & ~mask) | (value & mask);
  endfunction

  function automatic logic [PAT_W-1:0] rand_pattern();
    case ($urandom_range(5))
      0:       return $urandom();
      1:       return $urandom() & $urandom() & $urandom();
      2:       return $urandom() | $urandom();
      3:       return PAT_W'(1) << $urandom_range(PAT_W - 1);
      4:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [RULE_W-1:0] rand_rules();
    case ($urandom_range(3))
      0:       return {4{ACT_KEEP}};
      1:       return {4{ACT_FLIP}};
      default: return RULE_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] rand_limit();
    case ($urandom_range(3))
      0:       return '0;
      1:       return DIST_W'(512);
      2:       return DIST_W'($urandom_range(32));
      default: return DIST_W'($urandom_range(512));
    endcase
  endfunction

  function automatic logic [GEN_W-1:0] rand_gen_limit();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return GEN_W'($urandom_range(65535));
      default: return GEN_W'($urandom_range(40, 1));
    endcase
  endfunction

  // New rule set and search targets for the next walk
  task automatic random_setup();
    if ($urandom_range(4) == 0)
      write_reg(CFG_IDX_W'($urandom_range(15, 4)), $urandom());
    write_reg(CFG_INIT_PATTERN, rand_pattern());
    write_reg(CFG_RULE_CODES, with_noise(CFG_DAT_W'(rand_rules()), RULE_W));
    write_reg(CFG_DIST_LIMIT, with_noise(CFG_DAT_W'(rand_limit()), DIST_W));
    write_reg(CFG_MAX_GEN, with_noise(CFG_DAT_W'(rand_gen_limit()), GEN_W));
  endtask

  // Restart, then advance, with the odd restart along the way
  task automatic run_walk(input int unsigned steps);
    send_step(1'b1);
    for (int unsigned k = 0; k < steps; k++)
      send_step($urandom_range(99) < 5);
  endtask

  initial begin : stimulus
    int unsigned phase;
    sb            = new();
    items_sent    = 0;
    send_idle_pct = 25;
    recv_idle_pct = 25;
    hold_req      = 0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_INIT_PATTERN;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    restart_i     = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: empty row, keep-all rules, limit 1000
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    wait_drained();

    // Full row under flip-all: edges light up, notes clear, then back
    write_reg(CFG_INIT_PATTERN, '1);
    write_reg(CFG_RULE_CODES, CFG_DAT_W'({4{ACT_FLIP}}));
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    wait_drained();

    // Unused index dropped; generation limit of zero, distance limit of 512
    write_reg(SPARE_INDEX, $urandom());
    write_reg(CFG_INIT_PATTERN, 32'h8000_0001);
    write_reg(CFG_RULE_CODES, CFG_DAT_W'({ACT_FLIP, ACT_SET, ACT_CLEAR, ACT_KEEP}));
    write_reg(CFG_DIST_LIMIT, 32'd512);
    write_reg(CFG_MAX_GEN, '0);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b0);
    wait_drained();

    // Empty cells with no set neighbour are set; all-ones register data
    write_reg(CFG_INIT_PATTERN, 32'h0000_FFFF);
    write_reg(CFG_RULE_CODES, CFG_DAT_W'({ACT_KEEP, ACT_KEEP, ACT_KEEP, ACT_SET}));
    write_reg(CFG_DIST_LIMIT, 32'hFFFF_FC00);
    write_reg(CFG_MAX_GEN, '1);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b0);
    wait_drained();

    // Running past a small generation limit, found on even generations
    write_reg(CFG_INIT_PATTERN, 32'h0000_0001);
    write_reg(CFG_RULE_CODES, CFG_DAT_W'({4{ACT_FLIP}}));
    write_reg(CFG_MAX_GEN, 32'd2);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b0);
    send_step(1'b0);

    // Random walks under changing rule sets
    phase = 0;
    while (items_sent < 1500) begin
      wait_drained();
      if (phase >= 6 && phase < 12) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 25;
        recv_idle_pct = 25;
      end
      random_setup();
      // long output hold-off while requests keep coming
      if (phase == 15) hold_req++;
      run_walk($urandom_range(40, 4));
      phase++;
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS totalistic_ca_rhythm_search_core");
    end else begin
      $display("FAIL totalistic_ca_rhythm_search_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/tcrs_pkg.sv
src/tcrs_cfg_regs.sv
src/tcrs_cell_row.sv
src/tcrs_metric.sv
src/totalistic_ca_rhythm_search_core.sv
tb/sv/tb_totalistic_ca_rhythm_search_core.sv
